### src/pbfc_pkg.sv
// pbfc_pkg: widths, register indexes and constants of the PCM block fade block.
// Used by pcm_block_fade_clip_top; depends on nothing else.
package pbfc_pkg;

	// fixed field widths
	localparam int SAMPLE_W   = 32;
	localparam int HALF_W     = 16;
	localparam int LEN_W      = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// position counter and gain format
	localparam int POSITION_BITS  = 24;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
	localparam int CNT_W          = $clog2(GAIN_FRAC_BITS);
	localparam int SUM_W          = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
	localparam int PROD_W         = SAMPLE_W + GAIN_W;
	localparam int SHR_W          = PROD_W - GAIN_FRAC_BITS;

	localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
	localparam logic [GAIN_W-1:0]        GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
	localparam logic [LEN_W-1:0]         LEN_RESET = LEN_W'(44100);

	// saturation limits on the magnitude after the gain shift
	localparam logic [SHR_W-1:0] POS_LIM_16 = SHR_W'(32'h0000_7FFF);
	localparam logic [SHR_W-1:0] NEG_LIM_16 = SHR_W'(32'h0000_8000);
	localparam logic [SHR_W-1:0] POS_LIM_32 = SHR_W'(32'h7FFF_FFFF);
	localparam logic [SHR_W-1:0] NEG_LIM_32 = SHR_W'(32'h8000_0000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH = 2'd2;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_ARM    = 1'b1;

	// sample formats
	localparam logic WIDTH_16 = 1'b0;
	localparam logic WIDTH_32 = 1'b1;

endpackage

### src/pcm_block_fade_clip_top.sv
// pcm_block_fade_clip_top: linear fade gain over blocks of interleaved PCM samples.
// Holds a restoring divider, one multiplier and the saturation step.
// Depends on pbfc_pkg.
//
// Usage:
//  Input channel (in_valid / in_stall) carries operation, sample, end_of_frame
//  and end_of_block. An arm item (operation = 1) restarts the fade and gives
//  no result. Every sample item gives exactly one result on the output
//  channel (out_valid / out_stall): out_sample, block_last, fade_finished.
//  Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//  only while the block is idle.
// Sequence:
//  An arm item is handled in ST_IDLE alone. A sample item inside an open block,
//  or the first sample of a block while no fade runs, goes through ST_MUL
//  (multiply) and ST_OUT (saturate into the output register); the next item
//  is accepted only once the sequencer is back in ST_IDLE. The first sample
//  of a block during a fade first passes ST_PREP and ST_DIV for the gain
//  division, run one quotient bit a cycle in the divider. in_stall is high
//  while an item is being worked on.
// Reset: arst_n clears all control state; fade inactive, length 44100,
//  fade-out, sixteen-bit samples.
// Stall: the result sits in an output register; the next item is accepted
//  meanwhile and waits in its final step until the register frees.
module pcm_block_fade_clip_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [pbfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbfc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [pbfc_pkg::SAMPLE_W-1:0] sample,
	input  logic                              end_of_frame,
	input  logic                              end_of_block,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pbfc_pkg::SAMPLE_W-1:0] out_sample,
	output logic                              block_last,
	output logic                              fade_finished
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

	localparam int POS_W = pbfc_pkg::POSITION_BITS;
	localparam int LEN_W = pbfc_pkg::LEN_W;

	state_t state_q;

	// configuration
	logic [LEN_W-1:0] fade_length_q;
	logic             fade_in_q;
	logic             sample_width_q;

	// fade state
	logic             fade_active_q;
	logic [POS_W-1:0] fade_position_q;
	logic [POS_W-1:0] block_frames_q;
	logic             blk_open_q;
	logic             blk_counted_q;

	// per-item work registers
	logic [pbfc_pkg::GAIN_W-1:0]   gain_q;
	logic [LEN_W-1:0]              rem_q;
	logic [pbfc_pkg::CNT_W-1:0]    cnt_q;
	logic [pbfc_pkg::SAMPLE_W-1:0] mag_q;
	logic                          neg_q;
	logic                          eob_q;
	logic [pbfc_pkg::PROD_W-1:0]   prod_q;

	// output register
	logic                          out_valid_q;
	logic [pbfc_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                          block_last_q;
	logic                          fade_finished_q;

	logic in_accept;
	logic out_free;
	logic out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_OUT) && out_free;

	// sample magnitude in the configured width
	logic [pbfc_pkg::SAMPLE_W-1:0] sext_in;
	logic                          neg_in;
	logic [pbfc_pkg::SAMPLE_W-1:0] mag_in;

	always_comb begin
		if (sample_width_q == pbfc_pkg::WIDTH_32) begin
			sext_in = sample;
		end else begin
			sext_in = {{(pbfc_pkg::SAMPLE_W-pbfc_pkg::HALF_W){sample[pbfc_pkg::HALF_W-1]}},
				sample[pbfc_pkg::HALF_W-1:0]};
		end
		neg_in = sext_in[pbfc_pkg::SAMPLE_W-1];
		mag_in = neg_in ? (~sext_in + 1'b1) : sext_in;
	end

	// frame count of the open block after this item
	logic [POS_W-1:0] frames_base;
	logic [POS_W-1:0] frames_next;

	always_comb begin
		frames_base = blk_open_q ? block_frames_q : '0;
		if ((end_of_frame || end_of_block) && (frames_base != pbfc_pkg::POS_MAX)) begin
			frames_next = frames_base + 1'b1;
		end else begin
			frames_next = frames_base;
		end
	end

	// effective length and gain numerator
	logic [LEN_W-1:0]            len_eff;
	logic                        pos_ge_len;
	logic [LEN_W-1:0]            num;

	always_comb begin
		len_eff    = (fade_length_q == '0) ? LEN_W'(1) : fade_length_q;
		pos_ge_len = pbfc_pkg::SUM_W'(fade_position_q) >= pbfc_pkg::SUM_W'(len_eff);
		if (pos_ge_len) begin
			num = fade_in_q ? len_eff : '0;
		end else if (fade_in_q) begin
			num = LEN_W'(fade_position_q);
		end else begin
			num = len_eff - LEN_W'(fade_position_q);
		end
	end

	// divider step: shift remainder, subtract length when it fits
	logic [LEN_W:0] rem_sh;
	logic           qbit;

	assign rem_sh = {rem_q, 1'b0};
	assign qbit   = rem_sh >= {1'b0, len_eff};

	// saturate and restore sign
	logic [pbfc_pkg::SHR_W-1:0]    shr;
	logic [pbfc_pkg::SHR_W-1:0]    lim;
	logic [pbfc_pkg::SHR_W-1:0]    sat;
	logic [pbfc_pkg::SAMPLE_W-1:0] result;

	always_comb begin
		shr = prod_q[pbfc_pkg::PROD_W-1:pbfc_pkg::GAIN_FRAC_BITS];
		if (sample_width_q == pbfc_pkg::WIDTH_32) begin
			lim = neg_q ? pbfc_pkg::NEG_LIM_32 : pbfc_pkg::POS_LIM_32;
		end else begin
			lim = neg_q ? pbfc_pkg::NEG_LIM_16 : pbfc_pkg::POS_LIM_16;
		end
		sat    = (shr > lim) ? lim : shr;
		result = neg_q ? pbfc_pkg::SAMPLE_W'(-sat) : pbfc_pkg::SAMPLE_W'(sat);
	end

	// end-of-block position update
	logic [pbfc_pkg::SUM_W-1:0] new_pos;
	logic                       blk_end_upd;

	assign new_pos     = pbfc_pkg::SUM_W'(fade_position_q) + pbfc_pkg::SUM_W'(block_frames_q);
	assign blk_end_upd = eob_q && blk_counted_q && fade_active_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_length_q  <= pbfc_pkg::LEN_RESET;
			fade_in_q      <= 1'b0;
			sample_width_q <= pbfc_pkg::WIDTH_16;
		end else if (cfg_we) begin
			case (cfg_index)
				pbfc_pkg::REG_FADE_LENGTH:  fade_length_q  <= cfg_data[LEN_W-1:0];
				pbfc_pkg::REG_FADE_IN:      fade_in_q      <= cfg_data[0];
				pbfc_pkg::REG_SAMPLE_WIDTH: sample_width_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, fade state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			fade_active_q   <= 1'b0;
			fade_position_q <= '0;
			block_frames_q  <= '0;
			blk_open_q      <= 1'b0;
			blk_counted_q   <= 1'b0;
			out_valid_q     <= 1'b0;
			gain_q          <= '0;
			cnt_q           <= '0;
			rem_q           <= '0;
			mag_q           <= '0;
			neg_q           <= 1'b0;
			eob_q           <= 1'b0;
			prod_q          <= '0;
			out_sample_q    <= '0;
			block_last_q    <= 1'b0;
			fade_finished_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (operation == pbfc_pkg::OP_ARM) begin
							fade_active_q   <= 1'b1;
							fade_position_q <= '0;
							blk_counted_q   <= 1'b0;
						end else begin
							mag_q          <= mag_in;
							neg_q          <= neg_in;
							eob_q          <= end_of_block;
							block_frames_q <= frames_next;
							if (!blk_open_q) begin
								blk_open_q    <= 1'b1;
								blk_counted_q <= fade_active_q;
								if (fade_active_q) begin
									state_q <= ST_PREP;
								end else begin
									gain_q  <= pbfc_pkg::GAIN_ONE;
									state_q <= ST_MUL;
								end
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_PREP: begin
					// integer bit: numerator never exceeds length
					if (num == len_eff) begin
						gain_q <= pbfc_pkg::GAIN_W'(1);
						rem_q  <= '0;
					end else begin
						gain_q <= '0;
						rem_q  <= num;
					end
					cnt_q   <= pbfc_pkg::CNT_W'(pbfc_pkg::GAIN_FRAC_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// one fraction bit per cycle
					gain_q <= {gain_q[pbfc_pkg::GAIN_W-2:0], qbit};
					rem_q  <= qbit ? LEN_W'(rem_sh - {1'b0, len_eff}) : rem_sh[LEN_W-1:0];
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= pbfc_pkg::PROD_W'(mag_q) * pbfc_pkg::PROD_W'(gain_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register frees
					if (out_free) begin
						out_valid_q     <= 1'b1;
						out_sample_q    <= result;
						block_last_q    <= eob_q;
						fade_finished_q <= blk_end_upd && (new_pos > pbfc_pkg::SUM_W'(len_eff));
						if (blk_end_upd) begin
							fade_position_q <= (new_pos > pbfc_pkg::SUM_W'(pbfc_pkg::POS_MAX)) ?
								pbfc_pkg::POS_MAX : new_pos[POS_W-1:0];
							if (new_pos >= pbfc_pkg::SUM_W'(len_eff)) begin
								fade_active_q <= 1'b0;
							end
						end
						if (eob_q) begin
							blk_open_q     <= 1'b0;
							blk_counted_q  <= 1'b0;
							block_frames_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = out_sample_q;
	assign block_last    = block_last_q;
	assign fade_finished = fade_finished_q;

	// the finish flag only rides on a block's last result
	a_finish_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fade_finished_q |-> block_last_q)
		else $error("fade_finished without block_last");

	// an arm item leaves an active fade at position zero and gives no result
	a_arm_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (operation == pbfc_pkg::OP_ARM) |=>
		fade_active_q && (fade_position_q == '0) && (state_q == ST_IDLE))
		else $error("arm item did not restart the fade");

	// the latched gain never exceeds unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (gain_q <= pbfc_pkg::GAIN_ONE))
		else $error("gain above unity");

	// a sample item reaches the output step before the next item is taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (operation == pbfc_pkg::OP_SAMPLE) |=> in_stall)
		else $error("input accepted while an item is in work");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for pcm_block_fade_clip_top, fade gain ramp on PCM sample blocks.
// Directed table first, then random blocks in four idling phases; depends on pbfc_pkg.
module tb;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int DRAIN_CYCLES   = 32;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LIMIT    = 2000;
	localparam int MAX_GAP        = 40;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int PHASES         = 4;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [pbfc_pkg::SAMPLE_W-1:0] smp;
		logic                          last;
		logic                          fin;
	} result_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [pbfc_pkg::CFG_IDX_W-1:0]  cfg_idx;
		logic [pbfc_pkg::CFG_DATA_W-1:0] cfg_val;
		logic                            op;
		logic [pbfc_pkg::SAMPLE_W-1:0]   smp;
		logic                            eof;
		logic                            eob;
		logic                            typed;
		result_t                         want;
	} stim_row_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_we = 1'b0;
	logic [pbfc_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
	logic [pbfc_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic                                  operation = pbfc_pkg::OP_SAMPLE;
	logic signed [pbfc_pkg::SAMPLE_W-1:0]  sample = '0;
	logic                                  end_of_frame = 1'b0;
	logic                                  end_of_block = 1'b0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic signed [pbfc_pkg::SAMPLE_W-1:0]  out_sample;
	logic                                  block_last;
	logic                                  fade_finished;

	// bench-side copy of the block's registers and fade state
	logic [pbfc_pkg::LEN_W-1:0]         len_reg = pbfc_pkg::LEN_RESET;
	logic                               dir_reg = 1'b0;
	logic                               width_reg = pbfc_pkg::WIDTH_16;
	logic                               fade_on = 1'b0;
	logic [pbfc_pkg::POSITION_BITS-1:0] fade_pos = '0;
	logic [pbfc_pkg::POSITION_BITS-1:0] blk_frames = '0;
	logic [pbfc_pkg::GAIN_W-1:0]        blk_gain = '0;
	logic                               blk_open = 1'b0;
	logic                               blk_counted = 1'b0;

	result_t   scaled_q[$];
	stim_row_t dir_rows[$];
	int        err_cnt = 0;
	int        items_sent = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        hold_left = 0;
	bit        hold_req = 1'b0;
	int        quiet_cycles = 0;

	pcm_block_fade_clip_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.sample       (sample),
		.end_of_frame (end_of_frame),
		.end_of_block (end_of_block),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_sample   (out_sample),
		.block_last   (block_last),
		.fade_finished(fade_finished)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// gain latched at block start, unsigned with GAIN_FRAC_BITS fraction bits
	function automatic logic [pbfc_pkg::GAIN_W-1:0] ramp_gain();
		logic [63:0] len;
		logic [63:0] num;
		len = (len_reg == '0) ? 64'd1 : 64'(len_reg);
		if (!fade_on)
			return pbfc_pkg::GAIN_ONE;
		if (64'(fade_pos) >= len)
			num = dir_reg ? len : 64'd0;
		else
			num = dir_reg ? 64'(fade_pos) : len - 64'(fade_pos);
		return pbfc_pkg::GAIN_W'((num << pbfc_pkg::GAIN_FRAC_BITS) / len);
	endfunction

	// multiply by the block gain, truncate toward zero, clip to the sample width
	function automatic logic [pbfc_pkg::SAMPLE_W-1:0] apply_gain(
			logic [pbfc_pkg::SAMPLE_W-1:0] raw);
		logic [63:0] s;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] pos_lim;
		logic [63:0] neg_lim;
		if (width_reg == pbfc_pkg::WIDTH_32) begin
			s = {{32{raw[31]}}, raw};
			pos_lim = 64'h7FFF_FFFF;
			neg_lim = 64'h8000_0000;
		end else begin
			s = {{48{raw[15]}}, raw[15:0]};
			pos_lim = 64'h7FFF;
			neg_lim = 64'h8000;
		end
		mag = s[63] ? 64'd0 - s : s;
		prod = (mag * 64'(blk_gain)) >> pbfc_pkg::GAIN_FRAC_BITS;
		if (s[63]) begin
			if (prod > neg_lim)
				prod = neg_lim;
			return pbfc_pkg::SAMPLE_W'(64'd0 - prod);
		end
		if (prod > pos_lim)
			prod = pos_lim;
		return pbfc_pkg::SAMPLE_W'(prod);
	endfunction

	// advance the fade state by one item; returns 1 when the item gives a result
	function automatic bit fade_step(logic op, logic [pbfc_pkg::SAMPLE_W-1:0] smp, logic eof,
			logic eob, output result_t res);
		logic [63:0] len;
		logic [63:0] np;
		res = '0;
		if (op == pbfc_pkg::OP_ARM) begin
			fade_on = 1'b1;
			fade_pos = '0;
			blk_counted = 1'b0;
			return 1'b0;
		end
		if (!blk_open) begin
			blk_open = 1'b1;
			blk_frames = '0;
			blk_counted = fade_on;
			blk_gain = ramp_gain();
		end
		res.smp = apply_gain(smp);
		if ((eof || eob) && blk_frames < pbfc_pkg::POS_MAX)
			blk_frames = blk_frames + 1'b1;
		if (eob) begin
			if (blk_counted && fade_on) begin
				len = (len_reg == '0) ? 64'd1 : 64'(len_reg);
				np = 64'(fade_pos) + 64'(blk_frames);
				if (np > len)
					res.fin = 1'b1;
				if (np > 64'(pbfc_pkg::POS_MAX))
					np = 64'(pbfc_pkg::POS_MAX);
				fade_pos = np[pbfc_pkg::POSITION_BITS-1:0];
				if (64'(fade_pos) >= len)
					fade_on = 1'b0;
			end
			blk_open = 1'b0;
			blk_counted = 1'b0;
			blk_frames = '0;
		end
		res.last = eob;
		return 1'b1;
	endfunction

	function automatic stim_row_t cfg_row(logic [pbfc_pkg::CFG_IDX_W-1:0] idx,
			logic [pbfc_pkg::CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic stim_row_t item_row(logic op, logic [pbfc_pkg::SAMPLE_W-1:0] smp,
			logic eof, logic eob);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.op = op;
		r.smp = smp;
		r.eof = eof;
		r.eob = eob;
		return r;
	endfunction

	function automatic stim_row_t chk_row(logic [pbfc_pkg::SAMPLE_W-1:0] smp, logic eof,
			logic eob, logic [pbfc_pkg::SAMPLE_W-1:0] want_smp, logic want_last,
			logic want_fin);
		stim_row_t r;
		r = item_row(pbfc_pkg::OP_SAMPLE, smp, eof, eob);
		r.typed = 1'b1;
		r.want.smp = want_smp;
		r.want.last = want_last;
		r.want.fin = want_fin;
		return r;
	endfunction

	// offer one item after a random gap; record its expected result once accepted
	task automatic send_row(stim_row_t row);
		int gap;
		result_t res;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= row.op;
		sample <= row.smp;
		end_of_frame <= row.eof;
		end_of_block <= row.eob;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (fade_step(row.op, row.smp, row.eof, row.eob, res))
			scaled_q.push_back(row.typed ? row.want : res);
		items_sent++;
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [pbfc_pkg::CFG_IDX_W-1:0] idx,
			logic [pbfc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pbfc_pkg::REG_FADE_LENGTH:  len_reg = val[pbfc_pkg::LEN_W-1:0];
			pbfc_pkg::REG_FADE_IN:      dir_reg = val[0];
			pbfc_pkg::REG_SAMPLE_WIDTH: width_reg = val[0];
			default: ;
		endcase
	endtask

	function automatic logic [pbfc_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_7FFF;
			3: return 32'hFFFF_8000;
			4: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// mostly short fades so that they finish, with the extremes now and then
	function automatic logic [pbfc_pkg::CFG_DATA_W-1:0] pick_length();
		case ($urandom_range(19))
			0: return '0;
			1: return 24'd1;
			2: return 24'hFF_FFFF;
			3: return pbfc_pkg::CFG_DATA_W'($urandom());
			default: return pbfc_pkg::CFG_DATA_W'($urandom_range(40, 2));
		endcase
	endfunction

	// one block of interleaved frames, sometimes armed, broken or noisy
	task automatic send_block();
		int chans;
		int frames;
		int n;
		int arm_at;
		int r;
		bit noisy;
		logic eof;
		logic eob;
		chans = $urandom_range(4, 1);
		frames = $urandom_range(6, 1);
		n = chans * frames;
		arm_at = -1;
		r = $urandom_range(99);
		noisy = (r >= 30 && r < 36);
		if (r < 25)
			send_row(item_row(pbfc_pkg::OP_ARM, $urandom(), 1'($urandom_range(1)),
				1'($urandom_range(1))));
		else if (r < 30)
			arm_at = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			eof = ((i + 1) % chans == 0);
			eob = (i == n - 1);
			if (noisy) begin
				eof = 1'($urandom_range(1));
				eob = eob | ($urandom_range(9) == 0);
			end
			if (eob && $urandom_range(99) < 10)
				eof = 1'b0;
			if (i == arm_at)
				send_row(item_row(pbfc_pkg::OP_ARM, $urandom(), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			send_row(item_row(pbfc_pkg::OP_SAMPLE, pick_sample(), eof, eob));
		end
	endtask

	// receiver: random stall, or a long hold counted here when requested
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (scaled_q.size() == 0) begin
				err_cnt++;
				$display("%0t: result with nothing expected: out_sample %h block_last %b fade_finished %b",
					$time, out_sample, block_last, fade_finished);
			end else begin
				want = scaled_q.pop_front();
				if (out_sample !== want.smp) begin
					err_cnt++;
					$display("%0t: out_sample expected %h got %h", $time, want.smp, out_sample);
				end
				if (block_last !== want.last) begin
					err_cnt++;
					$display("%0t: block_last expected %b got %b", $time, want.last, block_last);
				end
				if (fade_finished !== want.fin) begin
					err_cnt++;
					$display("%0t: fade_finished expected %b got %b", $time, want.fin,
						fade_finished);
				end
			end
		end
	end

	// watchdog: end the run when no item moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int phase_send[PHASES];
		int phase_stall[PHASES];
		int target;
		int blk;
		phase_send = '{0, 70, 0, 29};
		phase_stall = '{0, 0, 70, 29};

		dir_rows = '{
			// after reset: no fade, unity gain, sixteen-bit
			chk_row(32'h0000_7FFF, 1'b1, 1'b0, 32'h0000_7FFF, 1'b0, 1'b0),
			chk_row(32'h1234_8000, 1'b1, 1'b1, 32'hFFFF_8000, 1'b1, 1'b0),
			cfg_row(pbfc_pkg::REG_SAMPLE_WIDTH, pbfc_pkg::CFG_DATA_W'(pbfc_pkg::WIDTH_32)),
			chk_row(32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0),
			chk_row(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0),
			// short fade-out that overshoots on a partial frame
			cfg_row(pbfc_pkg::REG_FADE_LENGTH, 24'd4),
			item_row(pbfc_pkg::OP_ARM, 32'hFFFF_FFFF, 1'b1, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h8000_0000, 1'b1, 1'b0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h4000_0000, 1'b1, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h0000_0005, 1'b0, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h1234_5678, 1'b1, 1'b1),
			// fade-in that lands exactly on its length
			cfg_row(pbfc_pkg::REG_FADE_IN, 24'd1),
			cfg_row(pbfc_pkg::REG_FADE_LENGTH, 24'd3),
			item_row(pbfc_pkg::OP_ARM, 32'h0000_0000, 1'b0, 1'b0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'hC000_0000, 1'b1, 1'b0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h3FFF_FFFF, 1'b0, 1'b1),
			// arm inside an open block
			item_row(pbfc_pkg::OP_SAMPLE, 32'h1111_1111, 1'b1, 1'b0),
			item_row(pbfc_pkg::OP_ARM, 32'h5555_AAAA, 1'b1, 1'b0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h2222_2222, 1'b1, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1),
			// zero length while the fade runs
			cfg_row(pbfc_pkg::REG_FADE_LENGTH, 24'd0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h8000_0001, 1'b1, 1'b1),
			// longest fade-out, then shrunk below its position
			cfg_row(pbfc_pkg::REG_SAMPLE_WIDTH, pbfc_pkg::CFG_DATA_W'(pbfc_pkg::WIDTH_16)),
			cfg_row(pbfc_pkg::REG_FADE_IN, 24'd0),
			cfg_row(pbfc_pkg::REG_FADE_LENGTH, 24'hFF_FFFF),
			item_row(pbfc_pkg::OP_ARM, 32'hAAAA_5555, 1'b0, 1'b1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'h0000_8000, 1'b1, 1'b0),
			item_row(pbfc_pkg::OP_SAMPLE, 32'hFFFF_7FFF, 1'b1, 1'b1),
			cfg_row(pbfc_pkg::REG_FADE_LENGTH, 24'd1),
			item_row(pbfc_pkg::OP_SAMPLE, 32'hFFFF_8000, 1'b1, 1'b1)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
			end else begin
				send_row(dir_rows[i]);
			end
		end

		// random blocks, one idling pattern per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			send_idle_pct = phase_send[ph];
			stall_pct = phase_stall[ph];
			write_reg(pbfc_pkg::REG_FADE_LENGTH, pick_length());
			write_reg(pbfc_pkg::REG_FADE_IN, pbfc_pkg::CFG_DATA_W'($urandom_range(1)));
			write_reg(pbfc_pkg::REG_SAMPLE_WIDTH, pbfc_pkg::CFG_DATA_W'($urandom_range(1)));
			target = items_sent + ITEMS_PER_PHASE;
			blk = 0;
			while (items_sent < target) begin
				send_block();
				blk++;
				// hold the receiver while items keep coming, to fill the block
				if (ph == 0 && blk == 8)
					hold_req = 1'b1;
				// pause until idle, then retune the fade, often mid-fade
				if (blk % 12 == 0) begin
					drain();
					write_reg(pbfc_pkg::REG_FADE_LENGTH, pick_length());
					if ($urandom_range(3) == 0)
						write_reg(pbfc_pkg::REG_FADE_IN,
							pbfc_pkg::CFG_DATA_W'($urandom_range(1)));
				end
			end
		end

		drain();
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
src/pbfc_pkg.sv
src/pcm_block_fade_clip_top.sv
bench/tb.sv
